FILE: rtl/ngr_pkg.sv
// Shared types, constants and tables for the NED to GPS report block.
package ngr_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    // register stages around the CORDIC iterations: input, gain, scale, output
    localparam int CORDIC_EXTRA      = 4;

    localparam logic [1:0] FIX_3D = 2'd3;

    localparam logic [15:0] COURSE_MAX = 16'd35999;

    // atan(2^-i) in centidegrees, 16 fraction bits, rounded
    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd294912000, 30'd174096719, 30'd91987925, 30'd46694507,
        30'd23437865,  30'd11730358,  30'd5866610,  30'd2933484,
        30'd1466765,   30'd733385,    30'd366694,   30'd183347,
        30'd91674,     30'd45837,     30'd22918,    30'd11459,
        30'd5730,      30'd2865,      30'd1432,     30'd716,
        30'd358,       30'd179,       30'd90,       30'd45,
        30'd22,        30'd11,        30'd6,        30'd3,
        30'd1,         30'd1,         30'd0,        30'd0
    };

    typedef enum logic [2:0] {
        REG_ORIGIN_LAT = 3'd0,
        REG_ORIGIN_LON = 3'd1,
        REG_ORIGIN_ALT = 3'd2,
        REG_LON_SCALE  = 3'd3,
        REG_SAT_COUNT  = 3'd4,
        REG_HORIZ_ACC  = 3'd5,
        REG_VERT_ACC   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic signed [31:0] alt;
        logic signed [15:0] vn;
        logic signed [15:0] ve;
        logic signed [15:0] vd;
    } report_t;

endpackage

FILE: rtl/ngr_cordic.sv
// Pipelined CORDIC vectoring unit: ground speed and course from N/E velocity.
module ngr_cordic #(
    parameter int STAGES = ngr_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [20:0] vel_north_mms,
    input  logic signed [20:0] vel_east_mms,
    output logic        [15:0] ground_speed_cms,
    output logic        [15:0] course_cdeg
);
    import ngr_pkg::*;

    localparam logic [29:0] GAIN_Q30   = 30'd652032874;
    localparam logic [23:0] DIV10_Q27  = 24'd13421773;
    localparam logic [29:0] Z_MAX      = 30'd589824000;
    localparam logic [15:0] HALF_TURN  = 16'd18000;
    localparam logic [15:0] FULL_TURN  = 16'd36000;

    // iteration registers, index 0 is the input stage
    logic signed [31:0] x_reg    [STAGES+1];
    logic signed [31:0] y_reg    [STAGES+1];
    logic signed [31:0] z_reg    [STAGES+1];
    logic               zero_reg [STAGES+1];
    logic               nneg_reg [STAGES+1];
    logic               eneg_reg [STAGES+1];

    logic [20:0] nmag_next;
    logic [20:0] emag_next;

    always_comb
    begin
        nmag_next = vel_north_mms[20] ? (~vel_north_mms + 21'd1) : vel_north_mms;
        emag_next = vel_east_mms[20]  ? (~vel_east_mms + 21'd1)  : vel_east_mms;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= $signed({3'd0, nmag_next, 8'd0});
            y_reg[0]    <= $signed({3'd0, emag_next, 8'd0});
            z_reg[0]    <= 32'sd0;
            zero_reg[0] <= (vel_north_mms == 21'sd0) && (vel_east_mms == 21'sd0);
            nneg_reg[0] <= vel_north_mms[20];
            eneg_reg[0] <= vel_east_mms[20];
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        logic signed [31:0] x_next;
        logic signed [31:0] y_next;
        logic signed [31:0] z_next;

        always_comb
        begin
            if (!y_reg[i][31])
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + $signed({2'd0, ATAN_TAB[i]});
            end
            else
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - $signed({2'd0, ATAN_TAB[i]});
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                zero_reg[i+1] <= zero_reg[i];
                nneg_reg[i+1] <= nneg_reg[i];
                eneg_reg[i+1] <= eneg_reg[i];
            end
        end
    end

    // gain stage: undo CORDIC gain, fold first-quadrant angle into a course
    logic [30:0] xc;
    logic [60:0] gain_prod;
    logic [29:0] zc;
    logic [13:0] quad_ang;
    logic [15:0] course_raw;
    logic [30:0] spdq_next;
    logic [15:0] crs_a_next;

    always_comb
    begin
        xc        = x_reg[STAGES][31] ? 31'd0 : x_reg[STAGES][30:0];
        gain_prod = 61'(xc) * 61'(GAIN_Q30);
        spdq_next = gain_prod[60:30];

        if (z_reg[STAGES][31])
            zc = 30'd0;
        else if (z_reg[STAGES][30:0] > 31'(Z_MAX))
            zc = Z_MAX;
        else
            zc = z_reg[STAGES][29:0];
        quad_ang = zc[29:16];

        priority if (zero_reg[STAGES])
            course_raw = 16'd0;
        else if (!nneg_reg[STAGES] && !eneg_reg[STAGES])
            course_raw = 16'(quad_ang);
        else if (nneg_reg[STAGES] && !eneg_reg[STAGES])
            course_raw = HALF_TURN - 16'(quad_ang);
        else if (nneg_reg[STAGES])
            course_raw = HALF_TURN + 16'(quad_ang);
        else
            course_raw = FULL_TURN - 16'(quad_ang);

        crs_a_next = (course_raw >= FULL_TURN) ? 16'd0 : course_raw;
    end

    logic [30:0] spdq_reg;
    logic [15:0] crs_a_reg;
    logic        zero_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spdq_reg   <= spdq_next;
            crs_a_reg  <= crs_a_next;
            zero_a_reg <= zero_reg[STAGES];
        end
    end

    // scale stage: q8 mm/s to cm/s is a drop of 8 bits and a divide by ten
    logic [46:0] div_next;
    logic [46:0] div_reg;
    logic [15:0] crs_b_reg;
    logic        zero_b_reg;

    assign div_next = 47'(spdq_reg[30:8]) * 47'(DIV10_Q27);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg    <= div_next;
            crs_b_reg  <= crs_a_reg;
            zero_b_reg <= zero_a_reg;
        end
    end

    // output stage
    logic [19:0] spd_q;
    logic [15:0] spd_next;
    logic [15:0] spd_reg;
    logic [15:0] crs_reg;

    always_comb
    begin
        spd_q = div_reg[46:27];
        if (zero_b_reg)
            spd_next = 16'd0;
        else if (spd_q > 20'd65535)
            spd_next = 16'hFFFF;
        else
            spd_next = spd_q[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spd_reg <= spd_next;
            crs_reg <= crs_b_reg;
        end
    end

    assign ground_speed_cms = spd_reg;
    assign course_cdeg      = crs_reg;

endmodule

FILE: rtl/ned_to_gps_report.sv
// Top level: NED position/velocity to GPS report, with APB register file.
// Throughput: one request per cycle; every stage moves together, and the
// whole pipe holds only while a finished report sits unread under rpt_stall.
// The CORDIC iteration chain, one iteration per stage, sets the depth.
// Reset clears the valid bits and loads the configuration reset values.
module ned_to_gps_report #(
    parameter int CORDIC_STAGES = ngr_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [4:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready,

    // request channel
    input  logic               req_valid,
    output logic               req_stall,
    input  logic signed [31:0] pos_north_mm,
    input  logic signed [31:0] pos_east_mm,
    input  logic signed [31:0] pos_down_mm,
    input  logic signed [20:0] vel_north_mms,
    input  logic signed [20:0] vel_east_mms,
    input  logic signed [20:0] vel_down_mms,

    // report channel
    output logic               rpt_valid,
    input  logic               rpt_stall,
    output logic signed [31:0] lat_e7,
    output logic signed [31:0] lon_e7,
    output logic signed [31:0] alt_mm,
    output logic signed [15:0] vn_cms,
    output logic signed [15:0] ve_cms,
    output logic signed [15:0] vd_cms,
    output logic        [15:0] ground_speed_cms,
    output logic        [15:0] course_cdeg,
    output logic        [1:0]  fix_kind,
    output logic        [7:0]  sats_out,
    output logic        [15:0] horiz_acc_out,
    output logic        [15:0] vert_acc_out
);
    import ngr_pkg::*;

    localparam int DEPTH      = CORDIC_STAGES + CORDIC_EXTRA;
    // position path is stages 0..4; the rest is a delay line to the output
    localparam int POS_STAGES = 4;
    localparam int DLY        = DEPTH - POS_STAGES;

    // latitude: north * 250 / 2783 per mm, reciprocal is floor(2^35*250/2783)
    localparam logic [31:0] LAT_RECIP = 32'd3086573694;
    localparam logic [7:0]  LAT_NUM   = 8'd250;
    localparam logic [12:0] LAT_DEN   = 13'd2783;
    // ceil(2^24/10): exact floor divide by ten for 21-bit magnitudes
    localparam logic [20:0] VEL_RECIP = 21'd1677722;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    logic [30:0] olat_reg;
    logic [31:0] olon_reg;
    logic [31:0] oalt_reg;
    logic [31:0] lon_scale_reg;
    logic [7:0]  sats_reg;
    logic [15:0] hacc_reg;
    logic [15:0] vacc_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            olat_reg      <= 31'd0;
            olon_reg      <= 32'd0;
            oalt_reg      <= 32'd0;
            lon_scale_reg <= 32'd1507121;
            sats_reg      <= 8'd0;
            hacc_reg      <= 16'd0;
            vacc_reg      <= 16'd0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ORIGIN_LAT: olat_reg      <= pwdata[30:0];
                REG_ORIGIN_LON: olon_reg      <= pwdata;
                REG_ORIGIN_ALT: oalt_reg      <= pwdata;
                REG_LON_SCALE:  lon_scale_reg <= pwdata;
                REG_SAT_COUNT:  sats_reg      <= pwdata[7:0];
                REG_HORIZ_ACC:  hacc_reg      <= pwdata[15:0];
                REG_VERT_ACC:   vacc_reg      <= pwdata[15:0];
                default: ;  // unmapped offset, write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ORIGIN_LAT: prdata = {1'b0, olat_reg};
            REG_ORIGIN_LON: prdata = olon_reg;
            REG_ORIGIN_ALT: prdata = oalt_reg;
            REG_LON_SCALE:  prdata = lon_scale_reg;
            REG_SAT_COUNT:  prdata = {24'd0, sats_reg};
            REG_HORIZ_ACC:  prdata = {16'd0, hacc_reg};
            REG_VERT_ACC:   prdata = {16'd0, vacc_reg};
            default:        prdata = 32'd0;
        endcase
    end

    //------------------------------------------------------------------
    // Pipeline control: one enable for every stage. A bubble in the pipe
    // costs nothing while the output side is free; everything freezes only
    // while the output register holds a report that is being stalled.
    //------------------------------------------------------------------
    logic [DEPTH-1:0] v_reg;
    logic             en;

    assign en        = !(v_reg[DEPTH-1] && rpt_stall);
    assign req_stall = v_reg[DEPTH-1] && rpt_stall;
    assign rpt_valid = v_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DEPTH-2:0], req_valid};
    end

    //------------------------------------------------------------------
    // Stage 0: request capture
    //------------------------------------------------------------------
    logic signed [31:0] north0_reg;
    logic signed [31:0] east0_reg;
    logic signed [31:0] down0_reg;
    logic signed [20:0] vel0_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            north0_reg  <= pos_north_mm;
            east0_reg   <= pos_east_mm;
            down0_reg   <= pos_down_mm;
            vel0_reg[0] <= vel_north_mms;
            vel0_reg[1] <= vel_east_mms;
            vel0_reg[2] <= vel_down_mms;
        end
    end

    //------------------------------------------------------------------
    // Stage 1: alt diff, multiplies (lat reciprocal, lon scale, velocity / 10)
    //------------------------------------------------------------------
    logic [31:0]        nmag_next;
    logic [63:0]        latp_next;
    logic signed [65:0] lprod_full;
    logic signed [32:0] alt1_next;
    logic [20:0]        vmag_next [3];
    logic [41:0]        vprod_next [3];

    always_comb
    begin
        nmag_next  = north0_reg[31] ? (~north0_reg + 32'd1) : north0_reg;
        latp_next  = 64'(nmag_next) * 64'(LAT_RECIP);
        lprod_full = $signed({east0_reg[31], east0_reg}) * $signed({1'b0, lon_scale_reg});
        alt1_next  = $signed({oalt_reg[31], oalt_reg}) - $signed({down0_reg[31], down0_reg});
        for (int k = 0; k < 3; k++)
        begin
            vmag_next[k]  = vel0_reg[k][20] ? (~vel0_reg[k] + 21'd1) : vel0_reg[k];
            vprod_next[k] = 42'(vmag_next[k]) * 42'(VEL_RECIP);
        end
    end

    logic [31:0]        nmag1_reg;
    logic               nneg1_reg;
    logic [63:0]        latp1_reg;
    logic signed [63:0] lprod1_reg;
    logic signed [32:0] alt1_reg;
    logic [41:0]        vprod1_reg [3];
    logic               vneg1_reg  [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag1_reg  <= nmag_next;
            nneg1_reg  <= north0_reg[31];
            latp1_reg  <= latp_next;
            lprod1_reg <= lprod_full[63:0];
            alt1_reg   <= alt1_next;
            for (int k = 0; k < 3; k++)
            begin
                vprod1_reg[k] <= vprod_next[k];
                vneg1_reg[k]  <= vel0_reg[k][20];
            end
        end
    end

    //------------------------------------------------------------------
    // Stage 2: lat quotient estimate and remainder, lon floor sum,
    //          altitude and velocity saturation
    //------------------------------------------------------------------
    function automatic logic signed [15:0] vel_sat(input logic [16:0] q, input logic neg);
        logic signed [15:0] r;
        if (neg)
            r = (q >= 17'd32768) ? 16'sh8000 : -$signed(q[15:0]);
        else
            r = (q >  17'd32767) ? 16'sh7FFF : $signed(q[15:0]);
        return r;
    endfunction

    logic [28:0]        qe_next;
    logic [40:0]        rem_full;
    logic signed [39:0] lon_fp;
    logic signed [40:0] lon_t_next;
    logic signed [31:0] alt2_next;
    logic signed [15:0] vel2_next [3];

    always_comb
    begin
        qe_next    = latp1_reg[63:35];
        rem_full   = 41'(nmag1_reg) * 41'(LAT_NUM) - 41'(qe_next) * 41'(LAT_DEN);
        lon_fp     = lprod1_reg[63:24];
        lon_t_next = $signed({{9{olon_reg[31]}}, olon_reg}) + $signed({lon_fp[39], lon_fp});
        if (alt1_reg[32] != alt1_reg[31])
            alt2_next = alt1_reg[32] ? S32_MIN : S32_MAX;
        else
            alt2_next = alt1_reg[31:0];
        for (int k = 0; k < 3; k++)
            vel2_next[k] = vel_sat(vprod1_reg[k][40:24], vneg1_reg[k]);
    end

    logic [28:0]        qe2_reg;
    logic [12:0]        rem2_reg;
    logic               nneg2_reg;
    logic signed [40:0] lon2_reg;
    logic               lnz2_reg;
    logic signed [31:0] alt2_reg;
    logic signed [15:0] vel2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qe2_reg   <= qe_next;
            rem2_reg  <= rem_full[12:0];
            nneg2_reg <= nneg1_reg;
            lon2_reg  <= lon_t_next;
            lnz2_reg  <= |lprod1_reg[23:0];
            alt2_reg  <= alt2_next;
            vel2_reg  <= vel2_next;
        end
    end

    //------------------------------------------------------------------
    // Stage 3: lat quotient fixup and signed floor, lon toward-zero fixup
    //------------------------------------------------------------------
    logic [28:0]        q_fix;
    logic [12:0]        r_fix;
    logic signed [29:0] q30;
    logic signed [29:0] fq_next;
    logic signed [40:0] lon3_next;

    always_comb
    begin
        // estimate is low by at most one
        if (rem2_reg >= LAT_DEN)
        begin
            q_fix = qe2_reg + 29'd1;
            r_fix = rem2_reg - LAT_DEN;
        end
        else
        begin
            q_fix = qe2_reg;
            r_fix = rem2_reg;
        end
        q30 = $signed({1'b0, q_fix});
        // floor of a negative quotient with a remainder is -(q+1) = ~q
        if (nneg2_reg)
            fq_next = (r_fix != 13'd0) ? ~q30 : -q30;
        else
            fq_next = q30;

        lon3_next = (lon2_reg[40] && lnz2_reg) ? lon2_reg + 41'sd1 : lon2_reg;
    end

    logic signed [29:0] fq3_reg;
    logic               rnz3_reg;
    logic signed [40:0] lon3_reg;
    logic signed [31:0] alt3_reg;
    logic signed [15:0] vel3_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fq3_reg  <= fq_next;
            rnz3_reg <= (r_fix != 13'd0);
            lon3_reg <= lon3_next;
            alt3_reg <= alt2_reg;
            vel3_reg <= vel2_reg;
        end
    end

    //------------------------------------------------------------------
    // Stage 4: lat toward-zero fixup (always in 32-bit range), lon clamp
    //------------------------------------------------------------------
    logic signed [31:0] lat_t;
    report_t            rep_next;

    always_comb
    begin
        lat_t = $signed({olat_reg[30], olat_reg}) + 32'(fq3_reg);
        rep_next.lat = (lat_t[31] && rnz3_reg) ? lat_t + 32'sd1 : lat_t;

        if (lon3_reg > 41'(S32_MAX))
            rep_next.lon = S32_MAX;
        else if (lon3_reg < 41'(S32_MIN))
            rep_next.lon = S32_MIN;
        else
            rep_next.lon = lon3_reg[31:0];

        rep_next.alt = alt3_reg;
        rep_next.vn  = vel3_reg[0];
        rep_next.ve  = vel3_reg[1];
        rep_next.vd  = vel3_reg[2];
    end

    // delay line to line up with the CORDIC output
    report_t rep_reg [DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rep_reg[0] <= rep_next;
            for (int k = 1; k < DLY; k++)
                rep_reg[k] <= rep_reg[k-1];
        end
    end

    //------------------------------------------------------------------
    // Speed and course
    //------------------------------------------------------------------
    ngr_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk              (clk),
        .en               (en),
        .vel_north_mms    (vel_north_mms),
        .vel_east_mms     (vel_east_mms),
        .ground_speed_cms (ground_speed_cms),
        .course_cdeg      (course_cdeg)
    );

    //------------------------------------------------------------------
    // Report outputs; copied fields come straight from the registers. The user
    // must, unchecked by the block, change them only while the block is idle
    //------------------------------------------------------------------
    assign lat_e7        = rep_reg[DLY-1].lat;
    assign lon_e7        = rep_reg[DLY-1].lon;
    assign alt_mm        = rep_reg[DLY-1].alt;
    assign vn_cms        = rep_reg[DLY-1].vn;
    assign ve_cms        = rep_reg[DLY-1].ve;
    assign vd_cms        = rep_reg[DLY-1].vd;
    assign fix_kind      = FIX_3D;
    assign sats_out      = sats_reg;
    assign horiz_acc_out = hacc_reg;
    assign vert_acc_out  = vacc_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_course_range: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid |-> course_cdeg <= COURSE_MAX)
        else $error("course out of range");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("valid bits moved while pipe frozen");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> v_reg[0])
        else $error("accepted request not in stage 0");

    a_reach_out: assert property (@(posedge clk) disable iff (!rst_n)
        en && v_reg[DEPTH-2] |=> rpt_valid)
        else $error("report lost before output register");

endmodule

FILE: dv/ned_to_gps_report_tb.sv
// Testbench for ned_to_gps_report: directed and random requests, checked against a local predictor.
`timescale 1ns / 100ps

module ned_to_gps_report_tb;
    import ngr_pkg::*;

    localparam int LATENCY        = CORDIC_STAGES_DEF + CORDIC_EXTRA;
    // Quiet cycles (no request and no report moving) before we give up.
    localparam int WATCHDOG_LIMIT = 2000;
    // Address slot past the last register; writes there must be dropped.
    localparam logic [2:0] REG_SPARE = 3'd7;

    localparam longint I32_MIN = -64'sh80000000;
    localparam longint I32_MAX = 64'sh7FFFFFFF;
    localparam int     VEL_MAX = 1000000;

    // One NED position/velocity request, at port widths.
    typedef struct {
        logic signed [31:0] north;
        logic signed [31:0] east;
        logic signed [31:0] down;
        logic signed [20:0] vn;
        logic signed [20:0] ve;
        logic signed [20:0] vd;
    } ned_sample_t;

    // One GPS report, at port widths.
    typedef struct {
        logic signed [31:0] lat_e7;
        logic signed [31:0] lon_e7;
        logic signed [31:0] alt_mm;
        logic signed [15:0] vn_cms;
        logic signed [15:0] ve_cms;
        logic signed [15:0] vd_cms;
        logic        [15:0] ground_speed_cms;
        logic        [15:0] course_cdeg;
        logic        [1:0]  fix_kind;
        logic        [7:0]  sats_out;
        logic        [15:0] horiz_acc_out;
        logic        [15:0] vert_acc_out;
    } gps_report_t;

    // ---------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ---------------------------------------------------------------
    logic               clk;
    logic               rst_n            = 1'b0;
    logic               psel             = 1'b0;
    logic               penable          = 1'b0;
    logic               pwrite           = 1'b0;
    logic        [4:0]  paddr            = '0;
    logic        [31:0] pwdata           = '0;
    logic        [31:0] prdata;
    logic               pready;
    logic               req_valid        = 1'b0;
    logic               req_stall;
    logic signed [31:0] pos_north_mm     = '0;
    logic signed [31:0] pos_east_mm      = '0;
    logic signed [31:0] pos_down_mm      = '0;
    logic signed [20:0] vel_north_mms    = '0;
    logic signed [20:0] vel_east_mms     = '0;
    logic signed [20:0] vel_down_mms     = '0;
    logic               rpt_valid;
    logic               rpt_stall        = 1'b0;
    logic signed [31:0] lat_e7;
    logic signed [31:0] lon_e7;
    logic signed [31:0] alt_mm;
    logic signed [15:0] vn_cms;
    logic signed [15:0] ve_cms;
    logic signed [15:0] vd_cms;
    logic        [15:0] ground_speed_cms;
    logic        [15:0] course_cdeg;
    logic        [1:0]  fix_kind;
    logic        [7:0]  sats_out;
    logic        [15:0] horiz_acc_out;
    logic        [15:0] vert_acc_out;

    // Shadow copy of the register file, reset values as in the block.
    logic signed [30:0] cfg_origin_lat = '0;
    logic signed [31:0] cfg_origin_lon = '0;
    logic signed [31:0] cfg_origin_alt = '0;
    logic        [31:0] cfg_lon_scale  = 32'd1507121;
    logic        [7:0]  cfg_sat_count  = '0;
    logic        [15:0] cfg_horiz_acc  = '0;
    logic        [15:0] cfg_vert_acc   = '0;

    gps_report_t expected_reports [$];

    // Idle percentages for the request sender and the report receiver.
    int snd_idle_pct     = 9;
    int rcv_idle_pct     = 50;
    int n_errors         = 0;
    int requests_sent    = 0;
    int reports_checked  = 0;
    int settings_loaded  = 0;
    int quiet_cycles     = 0;

    ned_to_gps_report uut (
        .clk, .rst_n,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .req_valid, .req_stall,
        .pos_north_mm, .pos_east_mm, .pos_down_mm,
        .vel_north_mms, .vel_east_mms, .vel_down_mms,
        .rpt_valid, .rpt_stall,
        .lat_e7, .lon_e7, .alt_mm, .vn_cms, .ve_cms, .vd_cms,
        .ground_speed_cms, .course_cdeg, .fix_kind, .sats_out,
        .horiz_acc_out, .vert_acc_out
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic longint saturate(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // atan(2^-i) in centidegrees, Q16, rounded
    function automatic longint atan_cdeg_q16(int i);
        case (i)
            0:  return 294912000;  1: return 174096719;  2: return 91987925;
            3:  return 46694507;   4: return 23437865;   5: return 11730358;
            6:  return 5866610;    7: return 2933484;    8: return 1466765;
            9:  return 733385;    10: return 366694;    11: return 183347;
            12: return 91674;     13: return 45837;     14: return 22918;
            15: return 11459;     16: return 5730;      17: return 2865;
            18: return 1432;      19: return 716;       20: return 358;
            21: return 179;       22: return 90;        23: return 45;
            24: return 22;        25: return 11;        26: return 6;
            27: return 3;         28: return 1;         29: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic gps_report_t predict_report(ned_sample_t s);
        gps_report_t r;
        longint north, east, down, vn, ve, vd;
        longint lat, prod, quot, rem, lon, alt;
        longint x, y, z, xs, ys, ang, course;
        longint unsigned spd;
        int i;
        north = s.north;
        east  = s.east;
        down  = s.down;
        vn    = s.vn;
        ve    = s.ve;
        vd    = s.vd;

        // 1e7/111320 per metre == 250/2783 per mm, exact, truncated toward zero
        lat = (longint'(cfg_origin_lat) * 2783 + north * 250) / 2783;
        lat = saturate(lat, I32_MIN, I32_MAX);

        // east * Q8.24 scale; the quotient/remainder fix-up truncates the sum toward zero
        prod = east * $signed({32'd0, cfg_lon_scale});
        quot = prod / 16777216;
        rem  = prod % 16777216;
        lon  = longint'(cfg_origin_lon) + quot;
        if (lon > 0 && rem < 0)
            lon = lon - 1;
        else if (lon < 0 && rem > 0)
            lon = lon + 1;
        lon = saturate(lon, I32_MIN, I32_MAX);

        alt = saturate(longint'(cfg_origin_alt) - down, I32_MIN, I32_MAX);

        // vectoring CORDIC on the first-quadrant vector (|vn|, |ve|), Q8 mm/s
        x = magnitude(vn) * 256;
        y = magnitude(ve) * 256;
        z = 0;
        for (i = 0; i < CORDIC_STAGES_DEF && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_cdeg_q16(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_cdeg_q16(i);
            end
        end
        z   = saturate(z, 0, 64'sd9000 * 65536);
        ang = z >>> 16;
        if (x < 0)
            x = 0;
        spd = (($unsigned(x) * 64'd652032874) >> 30) / 2560;
        if (spd > 65535)
            spd = 65535;

        // fold the first-quadrant angle back into the real quadrant
        if (vn == 0 && ve == 0)
        begin
            course = 0;
            spd    = 0;
        end
        else if (vn >= 0 && ve >= 0)
            course = ang;
        else if (vn < 0 && ve >= 0)
            course = 18000 - ang;
        else if (vn < 0)
            course = 18000 + ang;
        else
            course = 36000 - ang;
        if (course >= 36000)
            course = course - 36000;

        r.lat_e7           = 32'(lat);
        r.lon_e7           = 32'(lon);
        r.alt_mm           = 32'(alt);
        r.vn_cms           = 16'(saturate(vn / 10, -32768, 32767));
        r.ve_cms           = 16'(saturate(ve / 10, -32768, 32767));
        r.vd_cms           = 16'(saturate(vd / 10, -32768, 32767));
        r.ground_speed_cms = 16'(spd);
        r.course_cdeg      = 16'(course);
        r.fix_kind         = FIX_3D;
        r.sats_out         = cfg_sat_count;
        r.horiz_acc_out    = cfg_horiz_acc;
        r.vert_acc_out     = cfg_vert_acc;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Report checker: every accepted report against the oldest expectation
    // ---------------------------------------------------------------
    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge clk)
    begin : report_check
        gps_report_t want;
        if (rst_n && rpt_valid && !rpt_stall)
        begin
            reports_checked++;
            if (expected_reports.size() == 0)
            begin
                $error("report accepted with no request outstanding");
                n_errors++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("lat_e7", want.lat_e7, lat_e7);
                check_field("lon_e7", want.lon_e7, lon_e7);
                check_field("alt_mm", want.alt_mm, alt_mm);
                check_field("vn_cms", want.vn_cms, vn_cms);
                check_field("ve_cms", want.ve_cms, ve_cms);
                check_field("vd_cms", want.vd_cms, vd_cms);
                check_field("ground_speed_cms", want.ground_speed_cms, ground_speed_cms);
                check_field("course_cdeg", want.course_cdeg, course_cdeg);
                check_field("fix_kind", want.fix_kind, fix_kind);
                check_field("sats_out", want.sats_out, sats_out);
                check_field("horiz_acc_out", want.horiz_acc_out, horiz_acc_out);
                check_field("vert_acc_out", want.vert_acc_out, vert_acc_out);
            end
        end
    end

    // Receiver back-pressure, re-rolled every cycle.
    always @(negedge clk)
    begin
        rpt_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    // Watchdog: any cycle where a request or report moves resets the count.
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rpt_valid && !rpt_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Present one request (after a random sender gap) and hold it until taken.
    // valid stays high on return so back-to-back requests need no toggle.
    task automatic send_request(ned_sample_t s);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid     <= 1'b1;
        pos_north_mm  <= s.north;
        pos_east_mm   <= s.east;
        pos_down_mm   <= s.down;
        vel_north_mms <= s.vn;
        vel_east_mms  <= s.ve;
        vel_down_mms  <= s.vd;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        expected_reports.push_back(predict_report(s));
        requests_sent++;
    endtask

    // Drop valid, let every outstanding report drain, then wait out the pipe.
    task automatic wait_until_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, done on the edge with pready.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ORIGIN_LAT: cfg_origin_lat = value[30:0];
            REG_ORIGIN_LON: cfg_origin_lon = value;
            REG_ORIGIN_ALT: cfg_origin_alt = value;
            REG_LON_SCALE:  cfg_lon_scale  = value;
            REG_SAT_COUNT:  cfg_sat_count  = value[7:0];
            REG_HORIZ_ACC:  cfg_horiz_acc  = value[15:0];
            REG_VERT_ACC:   cfg_vert_acc   = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(longint lat, longint lon, longint alt,
                                 logic [31:0] scale, logic [7:0] sats,
                                 logic [15:0] hacc, logic [15:0] vacc);
        wait_until_drained();
        write_reg(REG_ORIGIN_LAT, 32'(lat));
        write_reg(REG_ORIGIN_LON, 32'(lon));
        write_reg(REG_ORIGIN_ALT, 32'(alt));
        write_reg(REG_LON_SCALE, scale);
        write_reg(REG_SAT_COUNT, sats);
        write_reg(REG_HORIZ_ACC, hacc);
        write_reg(REG_VERT_ACC, vacc);
        settings_loaded++;
    endtask

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic ned_sample_t make_sample(longint n, longint e, longint d,
                                                longint vn, longint ve, longint vd);
        ned_sample_t s;
        s.north = 32'(n);
        s.east  = 32'(e);
        s.down  = 32'(d);
        s.vn    = 21'(vn);
        s.ve    = 21'(ve);
        s.vd    = 21'(vd);
        return s;
    endfunction

    // Uniform in [lo, hi] with the two ends weighted up; span must fit 32 bits.
    function automatic longint pick_range(longint lo, longint hi);
        case ($urandom_range(5))
            0: return lo;
            1: return hi;
            default: return lo + longint'($urandom_range(32'(hi - lo)));
        endcase
    endfunction

    function automatic logic signed [31:0] rand_position();
        case ($urandom_range(7))
            0:       return 32'h80000000;
            1:       return 32'h7FFFFFFF;
            2, 3:    return $urandom;
            default: return int'($urandom_range(2000000)) - 1000000;
        endcase
    endfunction

    function automatic logic signed [20:0] rand_velocity();
        int v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = $urandom_range(1) ? VEL_MAX : -VEL_MAX;
            2, 3, 4: v = int'($urandom_range(2 * VEL_MAX)) - VEL_MAX;
            default: v = int'($urandom_range(6000)) - 3000;
        endcase
        return 21'(v);
    endfunction

    function automatic ned_sample_t random_sample();
        ned_sample_t s;
        s.north = rand_position();
        s.east  = rand_position();
        s.down  = rand_position();
        s.vn    = rand_velocity();
        s.ve    = rand_velocity();
        s.vd    = rand_velocity();
        return s;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset register values: zero velocity, due north, due east.
    task automatic test_reset_defaults();
        send_request(make_sample(0, 0, 0, 0, 0, 0));
        send_request(make_sample(1000, 1000, -500, 1000, 0, 0));
        send_request(make_sample(-1000, -2000, 500, 0, 1000, 0));
    endtask

    // Course in each quadrant and on the axes, including tiny vectors.
    task automatic test_course_quadrants();
        send_request(make_sample(10, 20, 30, 5000, 3000, 0));
        send_request(make_sample(10, 20, 30, -5000, 3000, 0));
        send_request(make_sample(10, 20, 30, -5000, -3000, 0));
        send_request(make_sample(10, 20, 30, 5000, -3000, 0));
        send_request(make_sample(10, 20, 30, 0, -1000, 0));
        send_request(make_sample(10, 20, 30, -1000, 0, 0));
        send_request(make_sample(10, 20, 30, 1, 1, 0));
        send_request(make_sample(10, 20, 30, -1, -1, 0));
    endtask

    // Register and field extremes: position, velocity and speed saturation.
    task automatic test_field_extremes();
        load_settings(900000000, 1800000000, I32_MAX, 32'hFFFFFFFF, 8'hFF,
                      16'hFFFF, 16'hFFFF);
        send_request(make_sample(I32_MAX, I32_MAX, I32_MIN, VEL_MAX, VEL_MAX, VEL_MAX));
        send_request(make_sample(I32_MIN, I32_MIN, I32_MAX, -VEL_MAX, -VEL_MAX, -VEL_MAX));
        load_settings(-900000000, -1800000000, I32_MIN, 32'd0, 8'd0, 16'd0, 16'd0);
        send_request(make_sample(I32_MIN, I32_MAX, I32_MAX, VEL_MAX, -VEL_MAX, -VEL_MAX));
        send_request(make_sample(I32_MAX, I32_MIN, I32_MIN, -VEL_MAX, VEL_MAX, VEL_MAX));
        // truncation toward zero, and the 16-bit velocity boundary
        send_request(make_sample(0, 0, 0, 9, -9, -19));
        send_request(make_sample(0, 0, 0, 327679, -327689, 327680));
        send_request(make_sample(0, 0, 0, -327680, 327690, -327679));
    endtask

    // A write to the slot past the last register must change nothing.
    task automatic test_unused_register();
        load_settings(123456789, -98765432, 4242, 32'd1507121, 8'd12, 16'd150, 16'd250);
        write_reg(REG_SPARE, 32'hFFFFFFFF);
        send_request(make_sample(5000, -5000, 100, 2500, -700, 30));
    endtask

    // Random requests under fresh random settings, in blocks.
    task automatic test_random_traffic(int snd_pct, int rcv_pct, int blocks, int per_block);
        longint scale;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        repeat (blocks)
        begin
            // mostly realistic longitude scales, sometimes the full Q8.24 range
            scale = $urandom_range(2) ? pick_range(0, 3000000) : pick_range(0, 64'hFFFFFFFF);
            load_settings(pick_range(-900000000, 900000000),
                          pick_range(-1800000000, 1800000000),
                          pick_range(I32_MIN, I32_MAX),
                          32'(scale),
                          8'(pick_range(0, 255)),
                          16'(pick_range(0, 65535)),
                          16'(pick_range(0, 65535)));
            repeat (per_block) send_request(random_sample());
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_course_quadrants();
        test_field_extremes();
        test_unused_register();

        test_random_traffic(9, 50, 3, 100);
        test_random_traffic(50, 9, 3, 100);
        test_random_traffic(0, 0, 3, 100);

        wait_until_drained();

        $display("Covered %0d requests and %0d reports under %0d register settings,",
                 requests_sent, reports_checked, settings_loaded);
        $display("with sender/receiver idle mixes of 9/50, 50/9 and none.");
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
